// ----- rtl/sfhm_pkg.sv -----
// Package with shared types and constants for the source freshness health monitor.
`timescale 1ns / 1ps
package sfhm_pkg;
   localparam int NUM_SOURCES = 9;
   localparam int NUM_LINKS = 5;
   localparam int SRC_IDX_W = 4;
   localparam int CNT_W = 32;
   localparam int TIME_WIDTH = 48;

   localparam logic [2:0] KIND_REGISTER = 3'd0;
   localparam logic [2:0] KIND_START = 3'd1;
   localparam logic [2:0] KIND_STOP = 3'd2;
   localparam logic [2:0] KIND_DATA = 3'd3;
   localparam logic [2:0] KIND_ERROR = 3'd4;
   localparam logic [2:0] KIND_SNAPSHOT = 3'd5;

   localparam logic [1:0] HEALTH_NONE = 2'd0;
   localparam logic [1:0] HEALTH_OK = 2'd1;
   localparam logic [1:0] HEALTH_TIMEOUT = 2'd2;

   localparam logic [1:0] ADDR_GRACE = 2'd0;
   localparam logic [31:0] GRACE_RESET = 32'd3000;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_APPLY = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   // Fields of one input transaction.
   typedef struct packed {
      logic [2:0] kind;
      logic [SRC_IDX_W-1:0] source;
      logic [TIME_WIDTH-1:0] value_ms;
      logic [TIME_WIDTH-1:0] now_ms;
   } req_payload_type;

   // Fields of one result transaction.
   typedef struct packed {
      logic accepted;
      logic [4:0] link_fresh_bits;
      logic [3:0] device_fresh_bits;
      logic [4:0] link_stale_bits;
      logic [7:0] error_class_bits;
      logic [1:0] overall_health;
      logic [CNT_W-1:0] snapshot_sequence;
      logic [CNT_W-1:0] timeout_events;
      logic [CNT_W-1:0] rejected_items;
      logic [TIME_WIDTH-1:0] snapshot_time_ms;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic apply;
      logic scan_clear;
      logic scan_step;
      logic [SRC_IDX_W-1:0] scan_index;
      logic finish;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_snapshot;
   } status_type;

   function automatic logic [7:0] err_class(input logic [SRC_IDX_W-1:0] idx);
      logic [7:0] r;
      r = '0;
      if (idx >= SRC_IDX_W'(7)) begin
         r[7] = 1'b1;
      end else begin
         r[idx[2:0]] = 1'b1;
      end
      return r;
   endfunction
endpackage

// ----- rtl/sfhm_ctrl.sv -----
// Controller state machine that sequences item handling and the snapshot scan.
`timescale 1ns / 1ps
module sfhm_ctrl
   import sfhm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input status_type status,
   output logic busy,
   output ctrl_type ctrl
);
   state_type state_ff, state_in;
   logic [SRC_IDX_W-1:0] idx_ff, idx_in;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      ctrl = '0;
      ctrl.scan_index = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (status.is_snapshot) begin
               ctrl.scan_clear = 1'b1;
               idx_in = '0;
               state_in = ST_SCAN;
            end else begin
               ctrl.apply = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            ctrl.scan_step = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SRC_IDX_W'(NUM_SOURCES - 1)) begin
               ctrl.apply = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            ctrl.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
      end
   end
endmodule

// ----- rtl/sfhm_datapath.sv -----
// Datapath holding per-source state, counters and the snapshot accumulators.
`timescale 1ns / 1ps
module sfhm_datapath
   import sfhm_pkg::*;
(
   input logic clock,
   input logic reset,
   input req_payload_type req_payload,
   input logic [31:0] grace_ms,
   input ctrl_type ctrl,
   output status_type status,
   output logic rsp_strobe,
   output rsp_payload_type rsp_payload
);
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   logic [2:0] kind_ff;
   logic [SRC_IDX_W-1:0] src_ff;
   logic [TIME_WIDTH-1:0] val_ff, now_ff;

   logic [NUM_SOURCES-1:0] reg_ff, has_ff, to_ff, err_ff;
   logic [TIME_WIDTH-1:0] max_age_ff [NUM_SOURCES];
   logic [TIME_WIDTH-1:0] data_t_ff [NUM_SOURCES];
   logic [TIME_WIDTH-1:0] err_t_ff [NUM_SOURCES];
   logic running_ff;
   logic [TIME_WIDTH-1:0] start_t_ff;
   logic [CNT_W-1:0] seq_ff, tout_ff, rej_ff;

   logic [4:0] lfresh_ff, lstale_ff;
   logic [3:0] dfresh_ff;
   logic [7:0] errs_ff;
   logic any_ff, unhealthy_ff;

   logic out_valid_ff, out_ok_ff;

   logic valid_src, ok, snap;
   logic [SRC_IDX_W-1:0] si;
   logic [TIME_WIDTH-1:0] s_age, s_data, grace, age_d, age_s;
   logic s_fresh, s_wait, s_to;

   assign valid_src = (src_ff < SRC_IDX_W'(NUM_SOURCES));
   assign snap = (kind_ff == KIND_SNAPSHOT);
   assign status.is_snapshot = snap;

   always_comb begin
      ok = 1'b0;
      case (kind_ff)
         KIND_REGISTER: ok = !running_ff && (val_ff != '0) && valid_src && !reg_ff[src_ff];
         KIND_START, KIND_STOP, KIND_SNAPSHOT: ok = 1'b1;
         KIND_DATA, KIND_ERROR: ok = valid_src && reg_ff[src_ff] && (val_ff != '0) &&
            (val_ff <= now_ff);
         default: ok = 1'b0;
      endcase
   end

   assign si = (ctrl.scan_index < SRC_IDX_W'(NUM_SOURCES)) ? ctrl.scan_index : '0;
   assign s_age = max_age_ff[si];
   assign s_data = data_t_ff[si];
   assign age_d = now_ff - s_data;
   assign age_s = now_ff - start_t_ff;
   assign grace = (s_age > TIME_WIDTH'(grace_ms)) ? s_age : TIME_WIDTH'(grace_ms);
   assign s_fresh = has_ff[si] && (now_ff >= s_data) && (age_d <= s_age);
   assign s_wait = !has_ff[si] && (now_ff >= start_t_ff) && (age_s <= grace);
   assign s_to = !s_fresh && !s_wait;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         kind_ff <= req_payload.kind;
         src_ff <= req_payload.source;
         val_ff <= req_payload.value_ms;
         now_ff <= req_payload.now_ms;
      end
      if (ctrl.apply && ok && kind_ff == KIND_REGISTER) begin
         max_age_ff[src_ff] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ff <= '0;
         has_ff <= '0;
         to_ff <= '0;
         err_ff <= '0;
         running_ff <= 1'b0;
         start_t_ff <= '0;
         seq_ff <= '0;
         tout_ff <= '0;
         rej_ff <= '0;
         out_valid_ff <= 1'b0;
         out_ok_ff <= 1'b0;
         lfresh_ff <= '0;
         lstale_ff <= '0;
         dfresh_ff <= '0;
         errs_ff <= '0;
         any_ff <= 1'b0;
         unhealthy_ff <= 1'b0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            data_t_ff[i] <= '0;
            err_t_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= ctrl.finish;
         if (ctrl.scan_clear) begin
            lfresh_ff <= '0;
            lstale_ff <= '0;
            dfresh_ff <= '0;
            errs_ff <= '0;
            any_ff <= 1'b0;
            unhealthy_ff <= 1'b0;
         end
         if (ctrl.scan_step && reg_ff[si]) begin
            any_ff <= 1'b1;
            to_ff[si] <= s_to;
            if (s_to) begin
               unhealthy_ff <= 1'b1;
               if (!to_ff[si] && tout_ff != CNT_MAX) begin
                  tout_ff <= tout_ff + 1'b1;
               end
            end
            if (s_fresh) begin
               if (si < SRC_IDX_W'(NUM_LINKS)) begin
                  lfresh_ff[si[2:0]] <= 1'b1;
               end else begin
                  dfresh_ff[2'(si - SRC_IDX_W'(NUM_LINKS))] <= 1'b1;
               end
            end else if (s_to && si < SRC_IDX_W'(NUM_LINKS)) begin
               lstale_ff[si[2:0]] <= 1'b1;
            end
            if (err_ff[si]) begin
               errs_ff <= errs_ff | err_class(si);
            end
         end
         if (ctrl.apply) begin
            out_ok_ff <= ok;
            if (!ok && rej_ff != CNT_MAX) begin
               rej_ff <= rej_ff + 1'b1;
            end
            if (ok) begin
               case (kind_ff)
                  KIND_REGISTER: begin
                     reg_ff[src_ff] <= 1'b1;
                     data_t_ff[src_ff] <= '0;
                     err_t_ff[src_ff] <= '0;
                     has_ff[src_ff] <= 1'b0;
                     to_ff[src_ff] <= 1'b0;
                     err_ff[src_ff] <= 1'b0;
                  end
                  KIND_START: begin
                     if (!running_ff) begin
                        running_ff <= 1'b1;
                        start_t_ff <= now_ff;
                     end
                  end
                  KIND_STOP: running_ff <= 1'b0;
                  KIND_DATA: begin
                     if (err_ff[src_ff] && val_ff > err_t_ff[src_ff]) begin
                        err_ff[src_ff] <= 1'b0;
                     end
                     data_t_ff[src_ff] <= val_ff;
                     has_ff[src_ff] <= 1'b1;
                     to_ff[src_ff] <= 1'b0;
                  end
                  KIND_ERROR: begin
                     err_ff[src_ff] <= 1'b1;
                     if (val_ff > err_t_ff[src_ff]) begin
                        err_t_ff[src_ff] <= val_ff;
                     end
                  end
                  KIND_SNAPSHOT: seq_ff <= seq_ff + 1'b1;
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb begin
      rsp_strobe = out_valid_ff;
      rsp_payload = '0;
      rsp_payload.accepted = out_ok_ff;
      rsp_payload.link_fresh_bits = snap ? lfresh_ff : '0;
      rsp_payload.device_fresh_bits = snap ? dfresh_ff : '0;
      rsp_payload.link_stale_bits = snap ? lstale_ff : '0;
      rsp_payload.error_class_bits = snap ? errs_ff : '0;
      rsp_payload.overall_health = !snap ? HEALTH_NONE : !any_ff ? HEALTH_NONE :
         unhealthy_ff ? HEALTH_TIMEOUT : HEALTH_OK;
      rsp_payload.snapshot_sequence = seq_ff;
      rsp_payload.timeout_events = tout_ff;
      rsp_payload.rejected_items = rej_ff;
      rsp_payload.snapshot_time_ms = snap ? now_ff : '0;
   end
endmodule

// ----- rtl/source_freshness_health_monitor.sv -----
// Top level of the source freshness health monitor with its register port.
`timescale 1ns / 1ps
// Issue a transaction on req_payload by raising start while busy is low. A non-snapshot
// transaction is loaded, applied and then returned; a snapshot visits the nine sources one
// per cycle through a single compare unit and is then returned. The result is shown on
// rsp_payload for one cycle marked by rsp_strobe and cannot be stalled. Times are 48
// bits wide. Register 0 at address 0 is the startup grace in milliseconds.
module source_freshness_health_monitor
   import sfhm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input req_payload_type req_payload,
   output logic rsp_strobe,
   output rsp_payload_type rsp_payload,
   input logic psel,
   input logic penable,
   input logic pwrite,
   input logic [1:0] paddr,
   input logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   logic [31:0] grace_ff;
   ctrl_type ctrl;
   status_type status;

   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_GRACE) ? grace_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         grace_ff <= GRACE_RESET;
      end else if (psel && penable && pwrite && paddr == ADDR_GRACE) begin
         grace_ff <= pwdata;
      end
   end

   sfhm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .status(status),
      .busy(busy), .ctrl(ctrl)
   );

   sfhm_datapath u_dp (
      .clock(clock), .reset(reset), .req_payload(req_payload), .grace_ms(grace_ff),
      .ctrl(ctrl), .status(status), .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   a_busy_on_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy did not rise after start");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$past(start && !busy)) else $error("result without work");
   a_health_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.overall_health == HEALTH_NONE ||
         rsp_payload.overall_health == HEALTH_OK ||
         rsp_payload.overall_health == HEALTH_TIMEOUT))
      else $error("bad health code");
endmodule
